// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pkcb_pkg.sv =====
// ---------------------------------------------------------------------------
// pkcb_pkg
// Shared types and constants of the palette-keyed clipped blitter.
// ---------------------------------------------------------------------------
package pkcb_pkg;

  // Number of palette entries and matching index width.
  localparam int PALETTE_SIZE = 256;
  localparam int INDEX_W      = $clog2(PALETTE_SIZE);

  // Default largest surface and window dimension.
  localparam int MAX_DIM_DEF  = 2048;

  // Fixed field widths.
  localparam int COLOR_W      = 16;
  localparam int COORD_W      = 11;
  localparam int REG_W        = 12;
  localparam int ADDR_W       = 22;
  localparam int CFG_IDX_W    = 3;

  // Request opcodes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_DEST_WIDTH  = 3'd2,
    CFG_DEST_HEIGHT = 3'd3,
    CFG_WINDOW_X    = 3'd4,
    CFG_WINDOW_Y    = 3'd5,
    CFG_WINDOW_W    = 3'd6,
    CFG_WINDOW_H    = 3'd7
  } cfg_reg_t;

  // Reset values of the destination width and height registers.
  localparam logic [REG_W-1:0] DEST_WIDTH_RST  = 12'd640;
  localparam logic [REG_W-1:0] DEST_HEIGHT_RST = 12'd480;

endpackage

// ===== hw/rtl/pkcb_ram.sv =====
// ---------------------------------------------------------------------------
// pkcb_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module pkcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hw/rtl/palette_keyed_clipped_blit_core.sv =====
// ---------------------------------------------------------------------------
// palette_keyed_clipped_blit_core
// Streams 8-bit palette-indexed pixels onto a 16-bit RGB565 surface.
// ---------------------------------------------------------------------------
// The blitter takes one request per clock while the result side does not stall
// and gives one result per draw request.
// A load request (opcode 0) writes one entry of the 256-entry palette in the
// cycle it is accepted and gives no result; a draw request accepted in the
// very next cycle already sees the new entry. A draw request (opcode 1) gives
// exactly one result: write_enable is set when the source pixel lies inside
// the source window, lands inside the destination surface after the signed
// offset, and its index is not zero (index zero is transparent). When it is
// set, dest_address is row times pitch plus column, wrapped to 22 bits, where
// the pitch is the destination width rounded up to even, and pixel_color is
// the palette entry; otherwise both read as zero. Dimensions above MAX_DIM are
// treated as MAX_DIM, and a zero window or surface size clips every pixel.
// The pipeline registers are the palette memory's registered read (first stage),
// the window and surface clip compares (second stage) and the row-times-pitch
// multiplier (output register). A stall on the result side freezes the whole
// pipeline, so a result waits in the output register while nothing is lost.
// Palette entries that were never loaded read back as unknown data.
// Configuration must be written only while no request is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_keyed_clipped_blit_core
  import pkcb_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [INDEX_W-1:0]   in_color_index,
  input  logic [COLOR_W-1:0]   in_palette_color,
  input  logic [COORD_W-1:0]   in_source_x,
  input  logic [COORD_W-1:0]   in_source_y,

  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_write_enable,
  output logic [ADDR_W-1:0]    out_dest_address,
  output logic [COLOR_W-1:0]   out_pixel_color,

  // Configuration write port.
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  // Width of a saturated dimension, of the pitch, of the signed clip math
  // and of the row-times-pitch product.
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int PITCH_W = $clog2(MAX_DIM + 2);
  localparam int CW      = (DIM_W + 1 > 13) ? DIM_W + 1 : 13;
  localparam int PROD_W  = DIM_W + PITCH_W;

  // -------------------------------------------------------------------------
  // Configuration registers.
  // -------------------------------------------------------------------------
  logic signed [REG_W-1:0]   offset_x_r, offset_y_r;
  logic        [REG_W-1:0]   dest_width_r, dest_height_r;
  logic        [COORD_W-1:0] window_x_r, window_y_r;
  logic        [REG_W-1:0]   window_w_r, window_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      dest_width_r  <= DEST_WIDTH_RST;
      dest_height_r <= DEST_HEIGHT_RST;
      window_x_r    <= '0;
      window_y_r    <= '0;
      window_w_r    <= '0;
      window_h_r    <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OFFSET_X:    offset_x_r    <= cfg_wdata;
        CFG_OFFSET_Y:    offset_y_r    <= cfg_wdata;
        CFG_DEST_WIDTH:  dest_width_r  <= cfg_wdata;
        CFG_DEST_HEIGHT: dest_height_r <= cfg_wdata;
        CFG_WINDOW_X:    window_x_r    <= cfg_wdata[COORD_W-1:0];
        CFG_WINDOW_Y:    window_y_r    <= cfg_wdata[COORD_W-1:0];
        CFG_WINDOW_W:    window_w_r    <= cfg_wdata;
        CFG_WINDOW_H:    window_h_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Dimensions saturated to MAX_DIM.
  logic [DIM_W-1:0] ww, wh, dw, dh;

  assign ww = (int'(window_w_r) > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(window_w_r);
  assign wh = (int'(window_h_r) > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(window_h_r);
  assign dw = (int'(dest_width_r) > MAX_DIM)  ? DIM_W'(MAX_DIM) : DIM_W'(dest_width_r);
  assign dh = (int'(dest_height_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dest_height_r);

  // -------------------------------------------------------------------------
  // Pipeline advance. All stages move together whenever the output register
  // is empty or its result is being taken.
  // -------------------------------------------------------------------------
  logic adv;
  logic accept;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // -------------------------------------------------------------------------
  // Palette memory. Loads write at acceptance; draws read at acceptance and
  // the data appears alongside the request in the first stage.
  // -------------------------------------------------------------------------
  logic               pal_we;
  logic               pal_re;
  logic [COLOR_W-1:0] pal_rdata;

  assign pal_we = accept && (in_opcode == OP_LOAD);
  assign pal_re = accept && (in_opcode == OP_DRAW);

  pkcb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_color_index),
    .wdata (in_palette_color),
    .re    (pal_re),
    .raddr (in_color_index),
    .rdata (pal_rdata)
  );

  // -------------------------------------------------------------------------
  // Stage 1: registered draw request. Load requests leave no entry here.
  // -------------------------------------------------------------------------
  logic               s1_valid_r;
  logic [INDEX_W-1:0] s1_index_r;
  logic [COORD_W-1:0] s1_sx_r, s1_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= pal_re;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_index_r <= in_color_index;
      s1_sx_r    <= in_source_x;
      s1_sy_r    <= in_source_y;
    end
  end

  // Clip math in signed arithmetic wide enough for offset plus difference.
  logic signed [CW-1:0] diff_x, diff_y, dx_s, dy_s;
  logic signed [CW-1:0] ww_s, wh_s, dw_s, dh_s;
  logic signed [CW-1:0] off_x_s, off_y_s;
  logic                 in_window, in_dest, s2_we_nxt;
  logic [PITCH_W-1:0]   pitch_sum;

  assign off_x_s = CW'(offset_x_r);
  assign off_y_s = CW'(offset_y_r);
  assign ww_s    = CW'(ww);
  assign wh_s    = CW'(wh);
  assign dw_s    = CW'(dw);
  assign dh_s    = CW'(dh);

  assign diff_x  = CW'(s1_sx_r) - CW'(window_x_r);
  assign diff_y  = CW'(s1_sy_r) - CW'(window_y_r);
  assign dx_s    = off_x_s + diff_x;
  assign dy_s    = off_y_s + diff_y;

  assign in_window = (diff_x >= 0) && (diff_x < ww_s) && (diff_y >= 0) && (diff_y < wh_s);
  assign in_dest   = (dx_s >= 0) && (dx_s < dw_s) && (dy_s >= 0) && (dy_s < dh_s);
  assign s2_we_nxt = in_window && in_dest && (s1_index_r != '0);

  // Pitch is the width rounded up to even.
  assign pitch_sum = PITCH_W'(dw) + PITCH_W'(1);

  // -------------------------------------------------------------------------
  // Stage 2: clip result, destination coordinates and palette color.
  // -------------------------------------------------------------------------
  logic               s2_valid_r;
  logic               s2_we_r;
  logic [DIM_W-1:0]   s2_dx_r, s2_dy_r;
  logic [PITCH_W-1:0] s2_pitch_r;
  logic [COLOR_W-1:0] s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_we_r    <= s2_we_nxt;
      s2_dx_r    <= dx_s[DIM_W-1:0];
      s2_dy_r    <= dy_s[DIM_W-1:0];
      s2_pitch_r <= {pitch_sum[PITCH_W-1:1], 1'b0};
      s2_color_r <= pal_rdata;
    end
  end

  // Row times pitch plus column, wrapped to the address width.
  logic [PROD_W-1:0] row_base;
  logic [ADDR_W-1:0] addr_sum;

  assign row_base = PROD_W'(s2_dy_r) * PROD_W'(s2_pitch_r);
  assign addr_sum = ADDR_W'(row_base) + ADDR_W'(s2_dx_r);

  // -------------------------------------------------------------------------
  // Output register. Clipped or transparent pixels carry zero address and
  // color.
  // -------------------------------------------------------------------------
  logic               out_valid_r;
  logic               out_we_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_we_r    <= s2_we_r;
      out_addr_r  <= s2_we_r ? addr_sum : '0;
      out_color_r <= s2_we_r ? s2_color_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_dest_address = out_addr_r;
  assign out_pixel_color  = out_color_r;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `ASSERT_IMPL(a_clip_zero, out_valid_r && !out_we_r, (out_addr_r == '0) && (out_color_r == '0), "clipped result carries nonzero payload")
  `ASSERT_IMPL(a_dx_in_surface, s2_valid_r && s2_we_r, (s2_dx_r < dw) && (s2_dy_r < dh), "written pixel lies outside the surface")
  `ASSERT_NEXT(a_stage_hold, in_stall && s2_valid_r, s2_valid_r && $stable(s2_color_r), "stage two changed under a stall")

endmodule
